// File: rtl/htfc_pkg.sv
// ----------------------------------------------------------------------------
// htfc_pkg
// Shared types, constants and the CRC-8 byte function for the humidity and
// temperature frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package htfc_pkg;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no final XOR
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Conversion constants: spans and offset in tenths, full scale in raw counts
  localparam int FullScale  = 65535;
  localparam int TempSpan   = 1750;
  localparam int TempOffset = 350;
  localparam int HumSpan    = 1000;

  // Field widths
  localparam int RawW      = 16;
  localparam int TempW     = 12;
  localparam int HumW      = 10;
  localparam int TempProdW = 27;  // 16-bit raw times 1750
  localparam int HumProdW  = 26;  // 16-bit raw times 1000
  localparam int TempQW    = TempProdW - RawW;
  localparam int HumQW     = HumProdW - RawW;

  // Sentinels sent on a checksum failure
  localparam logic signed [TempW-1:0] TempBad = -12'sd11;
  localparam logic [HumW-1:0]         HumBad  = 10'd1001;

  // Depth of the frame queue between front and back
  localparam int QueueDepth = 2;

  // One checked frame, handed from front to back
  typedef struct packed {
    logic [RawW-1:0] temp_raw;
    logic [RawW-1:0] hum_raw;
    logic            bad;
  } frame_t;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Fold one byte into the running CRC, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/htfc_in_if.sv
// ----------------------------------------------------------------------------
// htfc_in_if
// Byte channel into the frame checker: valid/ready with one reply byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/htfc_out_if.sv
// ----------------------------------------------------------------------------
// htfc_out_if
// Result channel out of the frame checker: valid/ready with the readings.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [htfc_pkg::TempW-1:0]      temp_tenths;
  logic        [htfc_pkg::HumW-1:0]       hum_tenths;
  logic                                   crc_error;

  modport source (output valid, output temp_tenths, output hum_tenths,
                  output crc_error, input ready);
  modport sink   (input valid, input temp_tenths, input hum_tenths,
                  input crc_error, output ready);
endinterface

`default_nettype wire

// File: rtl/htfc_front.sv
// ----------------------------------------------------------------------------
// htfc_front
// Byte front end: tracks the frame position, runs the CRC over each word,
// collects the raw words and pushes one checked frame per six bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module htfc_front (
  input  wire                     clk,
  input  wire                     rst,
  htfc_in_if.sink                 in_ch,
  input  htfc_pkg::queue_status_t q_status,
  output logic                    push,
  output htfc_pkg::frame_t        push_frame
);

  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  logic [2:0]                  byte_position;
  logic [7:0]                  running_crc;
  logic [htfc_pkg::RawW-1:0]   temp_raw;
  logic [htfc_pkg::RawW-1:0]   hum_raw;
  logic                        temp_crc_bad;

  logic [2:0] pos;
  logic       accept;
  logic [7:0] b;

  // Take bytes whenever the queue has room
  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  // Unreachable positions restart the frame
  assign pos = (byte_position > PosHumCrc) ? PosTempMsb : byte_position;

  // Push the finished frame on the humidity CRC byte
  assign push                = accept && (pos == PosHumCrc);
  assign push_frame.temp_raw = temp_raw;
  assign push_frame.hum_raw  = hum_raw;
  assign push_frame.bad      = temp_crc_bad || (b != running_crc);

  // Advance the frame state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= PosTempMsb;
      running_crc   <= htfc_pkg::CrcInit;
      temp_raw      <= '0;
      hum_raw       <= '0;
      temp_crc_bad  <= 1'b0;
    end else if (accept) begin
      case (pos)
        PosTempMsb: begin
          running_crc   <= htfc_pkg::crc8_byte(htfc_pkg::CrcInit, b);
          temp_raw      <= {b, temp_raw[7:0]};
          byte_position <= PosTempLsb;
        end
        PosTempLsb: begin
          running_crc   <= htfc_pkg::crc8_byte(running_crc, b);
          temp_raw      <= {temp_raw[15:8], b};
          byte_position <= PosTempCrc;
        end
        PosTempCrc: begin
          temp_crc_bad  <= (b != running_crc);
          running_crc   <= htfc_pkg::CrcInit;
          byte_position <= PosHumMsb;
        end
        PosHumMsb: begin
          running_crc   <= htfc_pkg::crc8_byte(htfc_pkg::CrcInit, b);
          hum_raw       <= {b, hum_raw[7:0]};
          byte_position <= PosHumLsb;
        end
        PosHumLsb: begin
          running_crc   <= htfc_pkg::crc8_byte(running_crc, b);
          hum_raw       <= {hum_raw[15:8], b};
          byte_position <= PosHumCrc;
        end
        PosHumCrc: begin
          running_crc   <= htfc_pkg::CrcInit;
          byte_position <= PosTempMsb;
        end
        default: begin
          byte_position <= PosTempMsb;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/htfc_queue.sv
// ----------------------------------------------------------------------------
// htfc_queue
// Small frame queue between the byte front end and the conversion back end.
// ----------------------------------------------------------------------------
`default_nettype none

module htfc_queue #(
  parameter int DEPTH = htfc_pkg::QueueDepth  // 2 or more
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  htfc_pkg::frame_t         push_frame,
  input  wire                      pop,
  output htfc_pkg::frame_t         pop_frame,
  output htfc_pkg::queue_status_t  status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  htfc_pkg::frame_t entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign pop_frame    = entries[rd_ptr];

  // Store pushed frames
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // Move pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/htfc_back.sv
// ----------------------------------------------------------------------------
// htfc_back
// Conversion back end: scales the raw words in a two-stage pipeline and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module htfc_back (
  input  wire                     clk,
  input  wire                     rst,
  input  htfc_pkg::queue_status_t q_status,
  input  htfc_pkg::frame_t        pop_frame,
  output logic                    pop,
  htfc_out_if.source              out_ch
);

  localparam int TW = htfc_pkg::TempProdW;
  localparam int HW = htfc_pkg::HumProdW;
  localparam int QT = htfc_pkg::TempQW;
  localparam int QH = htfc_pkg::HumQW;
  localparam logic [16:0] Scale17 = 17'(htfc_pkg::FullScale);
  localparam logic [TW-1:0] TempZero = TW'(htfc_pkg::TempOffset * htfc_pkg::FullScale);

  // Stage 1 registers
  logic            s1_valid;
  logic [TW-1:0]   s1_temp_prod;
  logic [HW-1:0]   s1_hum_prod;
  logic            s1_bad;

  // Output registers
  logic                                 out_valid;
  logic signed [htfc_pkg::TempW-1:0]    out_temp;
  logic [htfc_pkg::HumW-1:0]            out_hum;
  logic                                 out_err;

  logic advance;

  // Division by 65535 terms
  logic [QT-1:0]   t_q0;
  logic [16:0]     t_rem;
  logic            t_ge;
  logic [QT-1:0]   t_q;
  logic            t_rem_nz;
  logic            t_neg;
  logic signed [htfc_pkg::TempW-1:0] t_val;
  logic [QH-1:0]   h_q0;
  logic [16:0]     h_rem;
  logic            h_ge;
  logic [QH-1:0]   h_q;

  // Pipeline moves when the output register is free or being drained
  assign advance = !out_valid || out_ch.ready;
  assign pop     = advance && !q_status.empty;

  // Temperature: floor by estimate and one correction, round toward zero below offset
  always_comb begin
    t_q0     = s1_temp_prod[TW-1:16];
    t_rem    = {1'b0, s1_temp_prod[15:0]} + 17'(t_q0);
    t_ge     = (t_rem >= Scale17);
    t_q      = t_q0 + QT'(t_ge);
    t_rem_nz = t_ge ? (t_rem != Scale17) : (t_rem != '0);
    t_neg    = (s1_temp_prod < TempZero);
    t_val    = $signed({1'b0, t_q}) - 12'(htfc_pkg::TempOffset)
               + $signed({11'b0, t_neg && t_rem_nz});
  end

  // Humidity: floor by estimate and one correction
  always_comb begin
    h_q0  = s1_hum_prod[HW-1:16];
    h_rem = {1'b0, s1_hum_prod[15:0]} + 17'(h_q0);
    h_ge  = (h_rem >= Scale17);
    h_q   = h_q0 + QH'(h_ge);
  end

  // Control: valid bits for both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !q_status.empty;
      out_valid <= s1_valid;
    end
  end

  // Payload: multiply into stage 1, convert into the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_temp_prod <= TW'(pop_frame.temp_raw) * TW'(htfc_pkg::TempSpan);
      s1_hum_prod  <= HW'(pop_frame.hum_raw) * HW'(htfc_pkg::HumSpan);
      s1_bad       <= pop_frame.bad;
      if (s1_bad) begin
        out_temp <= htfc_pkg::TempBad;
        out_hum  <= htfc_pkg::HumBad;
      end else begin
        out_temp <= t_val;
        out_hum  <= h_q;
      end
      out_err <= s1_bad;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.temp_tenths = out_temp;
  assign out_ch.hum_tenths  = out_hum;
  assign out_ch.crc_error   = out_err;

endmodule

`default_nettype wire

// File: rtl/humidity_temp_frame_checker.sv
// Path: each frame passes the frame queue, stage 1 and the output register.
// Throughput: one byte per cycle, one result per six bytes; the front end only
// stalls when the frame queue is full, the back end only when the output waits.
// Reset: synchronous; restarts the frame at the first byte, loads the CRC with 0xFF,
// empties the frame queue and clears the pipeline valid bits.
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// Checks the six-byte humidity/temperature reply with CRC-8 and converts the
// two raw words into tenths of a degree and tenths of a percent.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_checker #(
  parameter int QUEUE_DEPTH = htfc_pkg::QueueDepth
) (
  input  wire         clk,
  input  wire         rst,
  htfc_in_if.sink     in_ch,
  htfc_out_if.source  out_ch
);

  logic                    push;
  htfc_pkg::frame_t        push_frame;
  logic                    pop;
  htfc_pkg::frame_t        pop_frame;
  htfc_pkg::queue_status_t q_status;

  // Byte intake and CRC checking
  htfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame)
  );

  // Frame queue between the two halves
  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (q_status)
  );

  // Scaling and result delivery
  htfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_frame (pop_frame),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/humidity_temp_frame_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker_tb
// Streams six-byte sensor replies into the frame checker: directed extremes
// and checksum failures first, then random frames with good and corrupted
// CRCs and misaligned runs. A scoreboard class decodes every accepted byte
// and compares each reading that leaves the block, field by field.
// ----------------------------------------------------------------------------

module humidity_temp_frame_checker_tb;

  localparam int ItemTarget   = 1850;
  localparam int QuietAfter   = 1600;
  localparam int HoldAfter    = 300;
  localparam int HoldCycles   = 400;
  localparam int DrainLimit   = 2000;
  localparam int ReportLimit  = 10;

  // Position within the reply
  typedef enum logic [2:0] {
    POS_TEMP_MSB, POS_TEMP_LSB, POS_TEMP_CRC,
    POS_HUM_MSB, POS_HUM_LSB, POS_HUM_CRC
  } reply_pos_t;

  // One converted reading
  typedef struct {
    logic signed [htfc_pkg::TempW-1:0] temp;
    logic [htfc_pkg::HumW-1:0]         hum;
    logic                              err;
  } reading_t;

  // --------------------------------------------------------------------------
  // Scoreboard: decodes accepted bytes and holds the readings still owed
  // --------------------------------------------------------------------------
  class reply_decoder_model;
    reply_pos_t                pos;
    logic [7:0]                crc_acc;
    logic [htfc_pkg::RawW-1:0] temp_word;
    logic [htfc_pkg::RawW-1:0] hum_word;
    bit                        temp_bad;
    reading_t                  owed_readings[$];
    int unsigned               faults;

    function new();
      pos       = POS_TEMP_MSB;
      crc_acc   = htfc_pkg::CrcInit;
      temp_word = '0;
      hum_word  = '0;
      temp_bad  = 1'b0;
      faults    = 0;
    endfunction

    // Shift one byte into the CRC, one data bit at a time
    static function logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ htfc_pkg::CrcPoly;
        end
      end
      return c;
    endfunction

    // Advance the decoder on one accepted byte
    function void note_byte(logic [7:0] b);
      reading_t r;
      longint   t_num;
      longint   t_val;
      longint   h_val;
      bit       bad;
      case (pos)
        POS_TEMP_MSB: begin
          crc_acc   = crc_fold(htfc_pkg::CrcInit, b);
          temp_word = {b, temp_word[7:0]};
          pos       = POS_TEMP_LSB;
        end
        POS_TEMP_LSB: begin
          crc_acc   = crc_fold(crc_acc, b);
          temp_word = {temp_word[15:8], b};
          pos       = POS_TEMP_CRC;
        end
        POS_TEMP_CRC: begin
          temp_bad = (b != crc_acc);
          crc_acc  = htfc_pkg::CrcInit;
          pos      = POS_HUM_MSB;
        end
        POS_HUM_MSB: begin
          crc_acc  = crc_fold(htfc_pkg::CrcInit, b);
          hum_word = {b, hum_word[7:0]};
          pos      = POS_HUM_LSB;
        end
        POS_HUM_LSB: begin
          crc_acc  = crc_fold(crc_acc, b);
          hum_word = {hum_word[15:8], b};
          pos      = POS_HUM_CRC;
        end
        POS_HUM_CRC: begin
          bad     = temp_bad || (b != crc_acc);
          crc_acc = htfc_pkg::CrcInit;
          pos     = POS_TEMP_MSB;
          if (bad) begin
            r.temp = htfc_pkg::TempBad;
            r.hum  = htfc_pkg::HumBad;
          end else begin
            // signed division truncates toward zero
            t_num  = longint'(temp_word) * htfc_pkg::TempSpan
                     - longint'(htfc_pkg::TempOffset) * htfc_pkg::FullScale;
            t_val  = t_num / htfc_pkg::FullScale;
            h_val  = (longint'(hum_word) * htfc_pkg::HumSpan) / htfc_pkg::FullScale;
            r.temp = t_val[htfc_pkg::TempW-1:0];
            r.hum  = h_val[htfc_pkg::HumW-1:0];
          end
          r.err = bad;
          owed_readings.push_back(r);
        end
        default: begin
          // unreachable positions restart the frame
          pos = POS_TEMP_MSB;
          note_byte(b);
        end
      endcase
    endfunction

    // Compare one result transaction against the oldest owed reading
    function void check_reading(reading_t got);
      reading_t want;
      if (owed_readings.size() == 0) begin
        faults++;
        if (faults <= ReportLimit) begin
          $display("%0t: unexpected reading temp=%0d hum=%0d err=%0b",
                   $realtime, got.temp, got.hum, got.err);
        end
        return;
      end
      want = owed_readings.pop_front();
      if (got.temp !== want.temp || got.hum !== want.hum || got.err !== want.err) begin
        faults++;
        if (faults <= ReportLimit) begin
          $display({"%0t: reading mismatch temp exp=%0d got=%0d",
                    " hum exp=%0d got=%0d err exp=%0b got=%0b"},
                   $realtime, want.temp, got.temp, want.hum, got.hum, want.err, got.err);
        end
      end
    endfunction

    // Count readings that never arrived
    function void close_out();
      if (owed_readings.size() != 0) begin
        faults += owed_readings.size();
        $display("%0t: %0d readings never arrived", $realtime, owed_readings.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic quiet;
  logic hold;
  int   bytes_sent;

  reply_decoder_model model;

  htfc_in_if  in_ch ();
  htfc_out_if out_ch ();

  humidity_temp_frame_checker dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive every input to a known value from time zero
  initial begin
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    out_ch.ready     <= 1'b0;
    quiet            = 1'b0;
    hold             <= 1'b0;
    bytes_sent       = 0;
    model            = new();
  end

  // --------------------------------------------------------------------------
  // Byte sender
  // --------------------------------------------------------------------------

  // Offer one byte, with an optional idle burst, and hold until accepted
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    model.note_byte(b);
    bytes_sent++;
    quiet = (bytes_sent >= QuietAfter);
  endtask

  // Send one reply; corrupt either CRC on request
  task automatic send_reply(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input bit spoil_temp, input bit spoil_hum);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = reply_decoder_model::crc_fold(
              reply_decoder_model::crc_fold(htfc_pkg::CrcInit, t_raw[15:8]), t_raw[7:0]);
    h_crc = reply_decoder_model::crc_fold(
              reply_decoder_model::crc_fold(htfc_pkg::CrcInit, h_raw[15:8]), h_raw[7:0]);
    if (spoil_temp) begin
      t_crc = t_crc ^ 8'($urandom_range(1, 255));
    end
    if (spoil_hum) begin
      h_crc = h_crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(t_raw[15:8]);
    send_byte(t_raw[7:0]);
    send_byte(t_crc);
    send_byte(h_raw[15:8]);
    send_byte(h_raw[7:0]);
    send_byte(h_crc);
  endtask

  // Pick a raw word, weighted toward the ends of the range
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 16));
      3:       return 16'($urandom_range(16'hFFEF, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int         r;
    int         k;
    logic [3:0] spoil;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of both words, then each checksum failure
    send_reply(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    send_reply(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_reply(16'h0001, 16'h8000, 1'b1, 1'b0);
    send_reply(16'h3333, 16'h0001, 1'b0, 1'b1);

    // Random: mostly good replies, some spoiled, some misaligned runs
    while (bytes_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // shift the framing, send a reply off-phase, then realign
        k = $urandom_range(1, 5);
        repeat (k) send_byte(8'($urandom));
        send_reply(pick_raw(), pick_raw(), 1'b0, 1'b0);
        repeat (6 - k) send_byte(8'($urandom));
      end else if (r < 25) begin
        spoil = 4'($urandom_range(1, 3));
        send_reply(pick_raw(), pick_raw(), spoil[0], spoil[1]);
      end else begin
        send_reply(pick_raw(), pick_raw(), 1'b0, 1'b0);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain the owed readings, then let the pipeline settle
    k = 0;
    while (model.owed_readings.size() != 0 && k < DrainLimit) begin
      @(posedge clk);
      k++;
    end
    repeat (10) @(posedge clk);
    model.close_out();
    if (model.faults == 0) begin
      $display("humidity_temp_frame_checker_tb: clean");
    end else begin
      $display("humidity_temp_frame_checker_tb: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result receiver
  // --------------------------------------------------------------------------
  initial begin
    int       stall_left;
    reading_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      // check a result transaction
      if (out_ch.valid && out_ch.ready) begin
        got.temp = out_ch.temp_tenths;
        got.hum  = out_ch.hum_tenths;
        got.err  = out_ch.crc_error;
        model.check_reading(got);
      end
      // pick the next ready: random stall bursts, plus the long hold-off
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      out_ch.ready <= !(stall_left > 0 || hold || rst);
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin
    wait (bytes_sent >= HoldAfter);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold <= 1'b0;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("humidity_temp_frame_checker_tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/htfc_pkg.sv
rtl/htfc_in_if.sv
rtl/htfc_out_if.sv
rtl/htfc_front.sv
rtl/htfc_queue.sv
rtl/htfc_back.sv
rtl/humidity_temp_frame_checker.sv
tb/humidity_temp_frame_checker_tb.sv
